/* rtl/core/size_class_free_list_allocator_core_assert.svh */
// Assertion macros for the size-class allocator core.
// Used by files that declare clk_i and rst_ni; no other dependencies.
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define SCA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define SCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sca_pkg.sv */
// Shared types, codes and constants of the size-class allocator core.
// No dependencies; imported by every module of the block.
package sca_pkg;

  localparam int DEF_NUM_CLASSES = 64;
  localparam int DEF_BLOCK_WORDS = 4096;
  localparam int DEF_NUM_BLOCKS  = 16;

  localparam int ADDR_SPACE = 65536;
  localparam int MAX_OPEN   = 31;
  localparam int APB_AW     = 3;

  localparam logic [16:0] EMPTY_MARK     = 17'h10000;
  localparam logic [4:0]  MAX_BLOCKS_RST = 5'd16;
  localparam logic        LIMIT_EN_RST   = 1'b1;

  typedef enum logic {
    REG_MAX_BLOCKS = 1'b0,
    REG_LIMIT_EN   = 1'b1
  } reg_idx_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_LIST     = 3'd0,
    ST_CARVED   = 3'd1,
    ST_ZERO     = 3'd2,
    ST_OVERSIZE = 3'd3,
    ST_TOO_BIG  = 3'd4,
    ST_LIMIT    = 3'd5,
    ST_FULL     = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_HEAD = 2'd1,
    S_LINK = 2'd2
  } state_e;

  typedef struct packed {
    logic        command;
    logic [12:0] size;
    logic [15:0] address;
  } in_item_t;

  typedef struct packed {
    logic [15:0] address_res;
    status_e     status;
    logic [4:0]  blocks_used;
    logic [16:0] words_carved;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic link_rd;
    logic commit_head;
    logic commit_link;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pop;
    logic slot_free;
  } dp_sts_t;

endpackage

/* rtl/core/sca_datapath.sv */
// Datapath: list head and link memories, bump arena registers, output register.
// Depends on sca_pkg and the assertion macro header.
`include "size_class_free_list_allocator_core_assert.svh"

module sca_datapath #(
  parameter int NUM_CLASSES = sca_pkg::DEF_NUM_CLASSES,
  parameter int BLOCK_WORDS = sca_pkg::DEF_BLOCK_WORDS,
  parameter int NUM_BLOCKS  = sca_pkg::DEF_NUM_BLOCKS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sca_pkg::ctl_cmd_t   cmd_i,
  output sca_pkg::dp_sts_t    sts_o,
  input  sca_pkg::in_item_t   in_item_i,
  input  logic [4:0]          max_blocks_i,
  input  logic                limit_en_i,
  output sca_pkg::out_item_t  out_item_o,
  output logic                out_valid_o,
  input  logic                out_stall_i
);
  import sca_pkg::*;

  localparam int CW = $clog2(NUM_CLASSES);

  // Item under work and registered head read
  in_item_t          item_q;
  logic [CW-1:0]     cls_q;
  logic [16:0]       head_mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] head_vld_q;
  logic [16:0]       head_rd_q;
  logic              head_rd_vld_q;
  logic [16:0]       link_mem [ADDR_SPACE];
  logic [16:0]       link_rd_q;

  // Arena state
  logic [16:0] nf_q, nf_d;
  logic [16:0] be_q, be_d;
  logic [4:0]  opened_q, opened_d;
  logic [16:0] carved_q, carved_d;

  out_item_t out_q, res;
  logic      out_valid_q;

  logic [16:0] head_w;
  logic        zero, over, is_free, legal, pop;
  logic        head_we;
  logic [16:0] head_wdata;

  logic [17:0] sum18;
  logic        need;
  logic [21:0] start22;
  logic [22:0] end23;
  logic        too_big, limit_hit, full;
  status_e     carve_st;
  logic [16:0] base;
  logic        carve_ok;

  assign head_w  = head_rd_vld_q ? head_rd_q : EMPTY_MARK;
  assign zero    = (item_q.size == 13'd0);
  assign over    = (item_q.size >= 13'(NUM_CLASSES));
  assign is_free = (item_q.command == CMD_FREE);
  assign legal   = !zero && !over;
  assign pop     = legal && !is_free && !head_w[16];

  assign head_we    = (cmd_i.commit_head && legal && is_free) || cmd_i.commit_link;
  assign head_wdata = cmd_i.commit_link ? link_rd_q : {1'b0, item_q.address};

  // Head memory with per-class valid bits; an invalid class reads as empty
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cls_q     <= in_item_i.size[CW-1:0];
      item_q    <= in_item_i;
      head_rd_q <= head_mem[in_item_i.size[CW-1:0]];
    end
    if (head_we) begin
      head_mem[cls_q] <= head_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q    <= '0;
      head_rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        head_rd_vld_q <= head_vld_q[in_item_i.size[CW-1:0]];
      end
      if (head_we) begin
        head_vld_q[cls_q] <= 1'b1;
      end
    end
  end

  // Link store: push writes the old head, pop reads the successor
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_head && legal && is_free) begin
      link_mem[item_q.address] <= head_w;
    end
    if (cmd_i.link_rd) begin
      link_rd_q <= link_mem[head_w[15:0]];
    end
  end

  // Bump carve
  always_comb begin
    sum18     = {1'b0, nf_q} + 18'(item_q.size);
    need      = sum18 > {1'b0, be_q};
    start22   = 22'(opened_q) * 22'(BLOCK_WORDS);
    end23     = {1'b0, start22} + 23'(BLOCK_WORDS);
    too_big   = 18'(item_q.size) > 18'(BLOCK_WORDS);
    limit_hit = limit_en_i && ((6'(opened_q) + 6'd1) > {1'b0, max_blocks_i});
    full      = (9'(opened_q) >= 9'(NUM_BLOCKS)) || (opened_q >= 5'(MAX_OPEN)) ||
                (end23 > 23'(ADDR_SPACE));
    if (!need)          carve_st = ST_CARVED;
    else if (too_big)   carve_st = ST_TOO_BIG;
    else if (limit_hit) carve_st = ST_LIMIT;
    else if (full)      carve_st = ST_FULL;
    else                carve_st = ST_CARVED;
    base     = need ? start22[16:0] : nf_q;
    carve_ok = cmd_i.commit_head && legal && !is_free && !pop && (carve_st == ST_CARVED);
  end

  always_comb begin
    nf_d     = nf_q;
    be_d     = be_q;
    opened_d = opened_q;
    carved_d = carved_q;
    if (carve_ok) begin
      nf_d     = base + 17'(item_q.size);
      carved_d = carved_q + 17'(item_q.size);
      if (need) begin
        be_d     = end23[16:0];
        opened_d = opened_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nf_q     <= '0;
      be_q     <= '0;
      opened_q <= '0;
      carved_q <= '0;
    end else begin
      nf_q     <= nf_d;
      be_q     <= be_d;
      opened_q <= opened_d;
      carved_q <= carved_d;
    end
  end

  // Result
  always_comb begin
    res.address_res  = 16'd0;
    res.blocks_used  = opened_d;
    res.words_carved = carved_d;
    if (zero) begin
      res.status = ST_ZERO;
    end else if (over) begin
      res.status = ST_OVERSIZE;
    end else if (is_free) begin
      res.status = ST_LIST;
    end else if (pop) begin
      res.status      = ST_LIST;
      res.address_res = head_w[15:0];
    end else begin
      res.status = carve_st;
      if (carve_st == ST_CARVED) begin
        res.address_res = base[15:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_head || cmd_i.commit_link) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit_head || cmd_i.commit_link) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_item_o      = out_q;
  assign out_valid_o     = out_valid_q;
  assign sts_o.pop       = pop;
  assign sts_o.slot_free = !out_valid_q || !out_stall_i;

  `SCA_ASSERT_IMP(a_no_head_pop, cmd_i.commit_head, !pop, "pop committed without link read")
  `SCA_ASSERT_IMP(a_open_step, opened_q != $past(opened_q), opened_q == $past(opened_q) + 5'd1, "block count jumped")
  `SCA_ASSERT_NEXT(a_link_follow, cmd_i.link_rd, cmd_i.commit_link || !sts_o.slot_free, "link data not consumed")

endmodule

/* rtl/core/sca_ctrl.sv */
// Controller state machine: sequences head read, link read and commit.
// Depends on sca_pkg.
module sca_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sca_pkg::dp_sts_t  sts_i,
  output sca_pkg::ctl_cmd_t cmd_o
);
  import sca_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_HEAD;
      end
      S_HEAD: begin
        if (sts_i.pop)            state_d = S_LINK;
        else if (sts_i.slot_free) state_d = S_IDLE;
      end
      S_LINK: begin
        if (sts_i.slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      S_HEAD: begin
        cmd_o.link_rd     = sts_i.pop;
        cmd_o.commit_head = !sts_i.pop && sts_i.slot_free;
      end
      S_LINK: begin
        cmd_o.commit_link = sts_i.slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/size_class_free_list_allocator_core.sv */
// Top level of the size-class free-list allocator: config registers and wiring.
// Depends on sca_pkg, sca_ctrl and sca_datapath.
// Usage:
// - Input channel (in_valid_i / in_stall_o / in_item_i): one item is an
//   allocate or free command with size and address. It is taken on an edge
//   where valid is high and stall is low.
// - Output channel (out_valid_o / out_stall_i / out_item_o): exactly one
//   result item per input item, in order: address, status, blocks opened
//   and total words carved after the command.
// - Sequence: free, errors and carves read the head memory, then commit;
//   a pop from a free list reads the head, then the link store, then commits,
//   since the link store read must land before the list head is rewritten.
//   The result appears in the output register in the cycle after the commit.
// - A stalled result holds in the output register; the next item is still
//   accepted and worked on, and holds at its commit until the slot drains.
// - Reset clears the arena pointers, counters and the per-class valid bits,
//   so every class list reads empty at once; no clearing pass is needed.
//   The link store is not cleared.
// - Config (APB, byte address 0: max_blocks, 4: limit_check_enable): user must
//   write only while the block is idle (not enforced); pready is always high.
module size_class_free_list_allocator_core #(
  parameter int NUM_CLASSES = sca_pkg::DEF_NUM_CLASSES,
  parameter int BLOCK_WORDS = sca_pkg::DEF_BLOCK_WORDS,
  parameter int NUM_BLOCKS  = sca_pkg::DEF_NUM_BLOCKS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  sca_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output sca_pkg::out_item_t         out_item_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sca_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import sca_pkg::*;

  logic [4:0] max_blocks_q;
  logic       limit_en_q;
  logic       cfg_we;
  reg_idx_e   cfg_idx;

  ctl_cmd_t ctl_cmd;
  dp_sts_t  dp_sts;

  // Register decode uses the word index; byte offset bits are ignored
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_blocks_q <= MAX_BLOCKS_RST;
      limit_en_q   <= LIMIT_EN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MAX_BLOCKS: max_blocks_q <= pwdata[4:0];
        REG_LIMIT_EN:   limit_en_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MAX_BLOCKS: prdata = {27'd0, max_blocks_q};
      REG_LIMIT_EN:   prdata = {31'd0, limit_en_q};
      default:        prdata = 32'd0;
    endcase
  end

  // Sequencer: idle -> head read -> (link read) -> commit
  sca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (ctl_cmd)
  );

  // Memories, arena registers and the output register
  sca_datapath #(
    .NUM_CLASSES (NUM_CLASSES),
    .BLOCK_WORDS (BLOCK_WORDS),
    .NUM_BLOCKS  (NUM_BLOCKS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctl_cmd),
    .sts_o        (dp_sts),
    .in_item_i    (in_item_i),
    .max_blocks_i (max_blocks_q),
    .limit_en_i   (limit_en_q),
    .out_item_o   (out_item_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i)
  );

endmodule
